[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define NSS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define NSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/nss_pkg.sv]
// Shared types, constants and helpers of the case-insensitive substring search.
package nss_pkg;

  // Default sizes
  localparam int PATTERN_MAX_DEF = 16;
  localparam int INDEX_WIDTH_DEF = 16;

  // Payload widths
  localparam int CMD_W         = 2;
  localparam int CH_W          = 8;
  localparam int MATCH_INDEX_W = 16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH  = 2'd2;

  // Character constants
  localparam logic [CH_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CH_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CH_W-1:0] CASE_GAP     = 8'h20;
  localparam logic [CH_W-1:0] BYTE_MASK    = 8'hFF;

  // Broadcast from the controller to every cell of the row
  typedef struct packed {
    logic            load;   // store data into the first free cell
    logic            step;   // advance match bits by one text byte
    logic            clear;  // drop pattern and match state
    logic [CH_W-1:0] data;   // folded byte
  } nss_bcast_t;

  // Fold a to z onto A to Z; everything else passes unchanged
  function automatic logic [CH_W-1:0] fold_upper(input logic [CH_W-1:0] b);
    logic [CH_W-1:0] r;
    r = b;
    if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
      r = (b - CASE_GAP) & BYTE_MASK;
    end
    return r;
  endfunction

endpackage

[src/nss_in_if.sv]
// Input channel: command and byte with valid/ready handshake.
interface nss_in_if;
  import nss_pkg::*;

  logic            valid;
  logic            ready;
  logic [CMD_W-1:0] cmd;
  logic [CH_W-1:0]  ch;

  modport source (output valid, output cmd, output ch, input ready);
  modport sink   (input valid, input cmd, input ch, output ready);
endinterface

[src/nss_out_if.sv]
// Result channel: search outcome with valid/ready handshake.
interface nss_out_if;
  import nss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [MATCH_INDEX_W-1:0] match_index;
  logic                     overflow;

  modport source (output valid, output found, output match_index, output overflow,
                  input ready);
  modport sink   (input valid, input found, input match_index, input overflow,
                  output ready);
endinterface

[src/nss_cell.sv]
// One cell of the match row: a pattern byte and its shift-and match bit.
module nss_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  nss_pkg::nss_bcast_t bcast,
  input  logic               prev_match,   // match bit of the cell to the left
  input  logic               prev_active,  // left neighbor holds a pattern byte
  input  logic               next_active,  // right neighbor holds a pattern byte
  output logic               match,
  output logic               active,
  output logic               hit           // this cell ends the pattern and matched now
);
  import nss_pkg::*;

  logic [CH_W-1:0] pat_r;
  logic            active_r, active_nxt;
  logic            match_r, match_nxt;
  logic            eq;
  logic            is_target;

  assign eq        = active_r && (pat_r == bcast.data) && prev_match;
  assign is_target = !active_r && prev_active;

  // Capture the pattern byte when this is the first free cell
  always_ff @(posedge clk) begin
    if (bcast.load && is_target) begin
      pat_r <= bcast.data;
    end
  end

  // Next active and match bit
  always_comb begin
    active_nxt = active_r;
    match_nxt  = match_r;
    if (bcast.clear) begin
      active_nxt = 1'b0;
      match_nxt  = 1'b0;
    end else begin
      if (bcast.load && is_target) begin
        active_nxt = 1'b1;
      end
      if (bcast.step) begin
        match_nxt = eq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      match_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      match_r  <= match_nxt;
    end
  end

  assign match  = match_r;
  assign active = active_r;
  assign hit    = bcast.step && eq && !next_active;
endmodule

[src/nss_chain.sv]
// Row of match cells; match bits move one cell right per text byte.
module nss_chain #(
  parameter int PATTERN_MAX = nss_pkg::PATTERN_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nss_pkg::nss_bcast_t bcast,
  output logic                hit
);
  import nss_pkg::*;

  logic [PATTERN_MAX-1:0] match_w;
  logic [PATTERN_MAX-1:0] active_w;
  logic [PATTERN_MAX-1:0] hit_w;

  // Wire each cell to its neighbors
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic prev_match, prev_active, next_active;

    if (k == 0) begin : g_first
      assign prev_match  = 1'b1;
      assign prev_active = 1'b1;
    end else begin : g_mid
      assign prev_match  = match_w[k-1];
      assign prev_active = active_w[k-1];
    end

    if (k == PATTERN_MAX - 1) begin : g_last
      assign next_active = 1'b0;
    end else begin : g_inner
      assign next_active = active_w[k+1];
    end

    nss_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .bcast       (bcast),
      .prev_match  (prev_match),
      .prev_active (prev_active),
      .next_active (next_active),
      .match       (match_w[k]),
      .active      (active_w[k]),
      .hit         (hit_w[k])
    );
  end

  // Only the last active cell can raise a hit
  assign hit = |hit_w;
endmodule

[src/nocase_substring_search_unit.sv]
// Case-insensitive substring search: one item per cycle unless stalled, result on finish.
// Items are taken one per cycle unless stalled: every text byte is compared against all
// stored pattern bytes at once, one comparator per cell of the match row, and the match
// vector advances by one cell in the same cycle. Pattern bytes (cmd 0) fill the row from
// the left, text bytes (cmd 1) stream through, and a finish (cmd 2) delivers one result in
// the cycle after it is taken, through an output register, and clears the search so the
// next pattern can load at once. The input stalls only while a result sits in the output
// register and the receiver is not ready. Letters a to z match their upper-case forms;
// other bytes match exactly. Pattern bytes past PATTERN_MAX and text past 2^INDEX_WIDTH
// bytes are dropped and reported through overflow.
module nocase_substring_search_unit #(
  parameter int PATTERN_MAX = nss_pkg::PATTERN_MAX_DEF,
  parameter int INDEX_WIDTH = nss_pkg::INDEX_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  nss_in_if.sink    in_ch,
  nss_out_if.source out_ch
);
  import nss_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic                     accept;
  logic                     is_pat, do_load, pat_over;
  logic                     is_text, do_step, text_over;
  logic                     do_finish;
  logic                     chain_hit;
  nss_bcast_t               bcast;

  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [INDEX_WIDTH:0]     pos_r, pos_nxt;
  logic                     seen_r, seen_nxt;
  logic [INDEX_WIDTH-1:0]   start_r, start_nxt;
  logic                     exceeded_r, exceeded_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     found_r;
  logic [MATCH_INDEX_W-1:0] index_r;
  logic                     ovf_r;

  // Decode the transfer
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_pat    = accept && (in_ch.cmd == CMD_PATTERN) && (pos_r == '0);
  assign do_load   = is_pat && (len_r < LEN_W'(PATTERN_MAX));
  assign pat_over  = is_pat && !do_load;
  assign is_text   = accept && (in_ch.cmd == CMD_TEXT);
  assign text_over = is_text && pos_r[INDEX_WIDTH];
  assign do_step   = is_text && !pos_r[INDEX_WIDTH];
  assign do_finish = accept && (in_ch.cmd == CMD_FINISH);

  // Broadcast to the cell row
  assign bcast.load  = do_load;
  assign bcast.step  = do_step;
  assign bcast.clear = do_finish;
  assign bcast.data  = fold_upper(in_ch.ch);

  nss_chain #(.PATTERN_MAX(PATTERN_MAX)) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .bcast (bcast),
    .hit   (chain_hit)
  );

  // Search state update
  always_comb begin
    len_nxt      = len_r;
    pos_nxt      = pos_r;
    seen_nxt     = seen_r;
    start_nxt    = start_r;
    exceeded_nxt = exceeded_r;
    if (do_finish) begin
      len_nxt      = '0;
      pos_nxt      = '0;
      seen_nxt     = 1'b0;
      start_nxt    = '0;
      exceeded_nxt = 1'b0;
    end else begin
      if (do_load) begin
        len_nxt = len_r + LEN_W'(1);
      end
      if (pat_over || text_over) begin
        exceeded_nxt = 1'b1;
      end
      if (do_step) begin
        pos_nxt = pos_r + (INDEX_WIDTH+1)'(1);
        if (chain_hit && !seen_r) begin
          seen_nxt  = 1'b1;
          start_nxt = pos_r[INDEX_WIDTH-1:0] + INDEX_WIDTH'(1) - INDEX_WIDTH'(len_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      pos_r      <= '0;
      seen_r     <= 1'b0;
      start_r    <= '0;
      exceeded_r <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      pos_r      <= pos_nxt;
      seen_r     <= seen_nxt;
      start_r    <= start_nxt;
      exceeded_r <= exceeded_nxt;
    end
  end

  // Hold the result until the receiver takes it
  assign out_valid_nxt = do_finish ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_finish) begin
      found_r <= (len_r == '0) || seen_r;
      index_r <= seen_r ? MATCH_INDEX_W'(start_r) : '0;
      ovf_r   <= exceeded_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = found_r;
  assign out_ch.match_index = index_r;
  assign out_ch.overflow    = ovf_r;
endmodule

[src/nss_checker.sv]
// Port-level checks for the substring search unit, bound to the top level.
`include "assert_macros.svh"

module nss_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [nss_pkg::CMD_W-1:0]         in_cmd,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_found,
  input logic [nss_pkg::MATCH_INDEX_W-1:0] out_index,
  input logic                              out_overflow
);
  import nss_pkg::*;

  // A finish transfer yields a result in the next cycle
  `NSS_ASSERT(a_finish_result, clk, rst_n, (in_valid && in_ready && in_cmd == CMD_FINISH) |=> out_valid, "finish without result")

  // A waiting result holds its payload
  `NSS_ASSERT(a_result_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_found) && $stable(out_index) && $stable(out_overflow)), "stalled result changed")

  // A stalled result blocks the input
  `NSS_ASSERT(a_backpressure, clk, rst_n, (out_valid && !out_ready) |-> !in_ready, "input open while result stalled")

  // No match reports index zero
  `NSS_ASSERT(a_miss_index, clk, rst_n, (out_valid && !out_found) |-> (out_index == '0), "nonzero index without match")

  // Reset leaves no result pending
  `NSS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")
endmodule

bind nocase_substring_search_unit nss_checker u_nss_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_cmd       (in_ch.cmd),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_found    (out_ch.found),
  .out_index    (out_ch.match_index),
  .out_overflow (out_ch.overflow)
);
